// ===== hw/rtl/ptzenc_pkg.sv =====
// Shared types and constants for the PTZ command frame encoder.
// Holds command codes, frame constants, the queue entry type and a clamp helper.
`timescale 1ns / 1ps

package ptzenc_pkg;

  typedef enum logic [3:0] {
    CMD_STOP         = 4'd0,
    CMD_UP           = 4'd1,
    CMD_DOWN         = 4'd2,
    CMD_LEFT         = 4'd3,
    CMD_RIGHT        = 4'd4,
    CMD_LEFT_UP      = 4'd5,
    CMD_LEFT_DOWN    = 4'd6,
    CMD_RIGHT_UP     = 4'd7,
    CMD_RIGHT_DOWN   = 4'd8,
    CMD_AUTO_SCAN    = 4'd9,
    CMD_SET_PRESET   = 4'd10,
    CMD_CLEAR_PRESET = 4'd11,
    CMD_CALL_PRESET  = 4'd12
  } cmd_t;

  localparam logic REG_PROTOCOL_SELECT = 1'b0;
  localparam logic REG_CAMERA_ADDRESS  = 1'b1;

  localparam logic [7:0] D_SYNC       = 8'hFF;
  localparam logic [7:0] P_STX        = 8'hA0;
  localparam logic [7:0] P_ETX        = 8'hAF;
  localparam logic [7:0] SPEED_MAX    = 8'h3F;
  localparam logic [7:0] P_TURBO      = 8'h40;
  localparam logic [7:0] D_TURBO      = 8'hFF;
  localparam logic [7:0] BIT_UP       = 8'h08;
  localparam logic [7:0] BIT_DOWN     = 8'h10;
  localparam logic [7:0] BIT_LEFT     = 8'h04;
  localparam logic [7:0] BIT_RIGHT    = 8'h02;
  localparam logic [7:0] D_SCAN       = 8'h98;
  localparam logic [7:0] P_SCAN       = 8'h20;
  localparam logic [7:0] OP_SET       = 8'h03;
  localparam logic [7:0] OP_CLEAR     = 8'h05;
  localparam logic [7:0] OP_CALL      = 8'h07;
  localparam logic [7:0] D_PRESET_MAX = 8'h20;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Byte positions inside a frame.
  localparam logic [2:0] POS_HEAD  = 3'd0;
  localparam logic [2:0] POS_ADDR  = 3'd1;
  localparam logic [2:0] POS_CMD1  = 3'd2;
  localparam logic [2:0] POS_CMD2  = 3'd3;
  localparam logic [2:0] POS_DATA1 = 3'd4;
  localparam logic [2:0] POS_DATA2 = 3'd5;
  localparam logic [2:0] POS_SIX   = 3'd6;
  localparam logic [2:0] POS_SEVEN = 3'd7;

  typedef struct packed {
    logic       is_p;
    logic [7:0] addr;
    logic [7:0] cmd1;
    logic [7:0] cmd2;
    logic [7:0] data1;
    logic [7:0] data2;
    logic [7:0] check;
  } frame_desc_t;

  typedef struct packed {
    logic        wr_en;
    frame_desc_t wr_data;
  } q_wr_t;

  typedef struct packed {
    logic        empty;
    frame_desc_t rd_data;
  } q_rd_t;

  function automatic logic [7:0] clamp3f(input logic [7:0] v);
    clamp3f = (v > SPEED_MAX) ? SPEED_MAX : v;
  endfunction

endpackage

// ===== hw/rtl/ptzenc_front.sv =====
// Front end: configuration registers, command decode and frame field build.
// Depends on ptzenc_pkg; writes one frame descriptor per accepted command.
`timescale 1ns / 1ps

module ptzenc_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic                   cfg_index,
  input  logic [7:0]             cfg_data,
  input  logic                   push,
  input  logic                   q_full,
  input  logic [3:0]             cmd,
  input  logic                   enable,
  input  logic [7:0]             pan_speed,
  input  logic [7:0]             tilt_speed,
  input  logic [7:0]             preset_number,
  output ptzenc_pkg::q_wr_t      q_wr
);

  logic       protocol_select;
  logic [7:0] camera_address;

  always_ff @(posedge clk) begin
    if (rst) begin
      protocol_select <= 1'b0;
      camera_address  <= 8'h01;
    end else if (cfg_we) begin
      if (cfg_index == ptzenc_pkg::REG_PROTOCOL_SELECT) begin
        protocol_select <= cfg_data[0];
      end else begin
        camera_address <= cfg_data;
      end
    end
  end

  logic       is_d;
  logic       frame_ok;
  logic [7:0] c1, c2, d1, d2;
  logic [7:0] pan_c, tilt_c, preset_c;
  logic [7:0] sum, xr;

  always_comb begin
    is_d     = !protocol_select;
    pan_c    = ptzenc_pkg::clamp3f(pan_speed);
    tilt_c   = ptzenc_pkg::clamp3f(tilt_speed);
    preset_c = (preset_number == 8'h00) ? 8'h01 : preset_number;
    if (is_d && preset_c > ptzenc_pkg::D_PRESET_MAX) begin
      preset_c = ptzenc_pkg::D_PRESET_MAX;
    end
    c1       = 8'h00;
    c2       = 8'h00;
    d1       = 8'h00;
    d2       = 8'h00;
    frame_ok = 1'b1;
    unique case (cmd)
      ptzenc_pkg::CMD_STOP: begin
      end
      ptzenc_pkg::CMD_UP: begin
        c2 = ptzenc_pkg::BIT_UP;
        d2 = tilt_c;
      end
      ptzenc_pkg::CMD_DOWN: begin
        c2 = ptzenc_pkg::BIT_DOWN;
        d2 = tilt_c;
      end
      ptzenc_pkg::CMD_LEFT, ptzenc_pkg::CMD_RIGHT: begin
        c2 = (cmd == ptzenc_pkg::CMD_LEFT) ? ptzenc_pkg::BIT_LEFT : ptzenc_pkg::BIT_RIGHT;
        if (pan_speed > ptzenc_pkg::SPEED_MAX) begin
          d1 = is_d ? ptzenc_pkg::D_TURBO : ptzenc_pkg::P_TURBO;
        end else begin
          d1 = pan_speed;
        end
      end
      ptzenc_pkg::CMD_LEFT_UP: begin
        c2 = ptzenc_pkg::BIT_LEFT | ptzenc_pkg::BIT_UP;
        d1 = pan_c;
        d2 = tilt_c;
      end
      ptzenc_pkg::CMD_LEFT_DOWN: begin
        c2 = ptzenc_pkg::BIT_LEFT | ptzenc_pkg::BIT_DOWN;
        d1 = pan_c;
        d2 = tilt_c;
      end
      ptzenc_pkg::CMD_RIGHT_UP: begin
        c2 = ptzenc_pkg::BIT_RIGHT | ptzenc_pkg::BIT_UP;
        d1 = pan_c;
        d2 = tilt_c;
      end
      ptzenc_pkg::CMD_RIGHT_DOWN: begin
        c2 = ptzenc_pkg::BIT_RIGHT | ptzenc_pkg::BIT_DOWN;
        d1 = pan_c;
        d2 = tilt_c;
      end
      ptzenc_pkg::CMD_AUTO_SCAN: begin
        c1 = is_d ? ptzenc_pkg::D_SCAN : ptzenc_pkg::P_SCAN;
        d1 = pan_c;
        d2 = tilt_c;
      end
      ptzenc_pkg::CMD_SET_PRESET: begin
        c2 = ptzenc_pkg::OP_SET;
        d2 = preset_c;
      end
      ptzenc_pkg::CMD_CLEAR_PRESET: begin
        c2 = ptzenc_pkg::OP_CLEAR;
        d2 = preset_c;
      end
      ptzenc_pkg::CMD_CALL_PRESET: begin
        c2 = ptzenc_pkg::OP_CALL;
        d2 = preset_c;
      end
      default: begin
        frame_ok = 1'b0;
      end
    endcase
    // drop moves and scans while enable is low
    if (cmd >= ptzenc_pkg::CMD_UP && cmd <= ptzenc_pkg::CMD_AUTO_SCAN && !enable) begin
      frame_ok = 1'b0;
    end
    sum = camera_address + c1 + c2 + d1 + d2;
    xr  = camera_address ^ c1 ^ c2 ^ d1 ^ d2;

    q_wr.wr_en         = push && !q_full && frame_ok;
    q_wr.wr_data.is_p  = protocol_select;
    q_wr.wr_data.addr  = camera_address;
    q_wr.wr_data.cmd1  = c1;
    q_wr.wr_data.cmd2  = c2;
    q_wr.wr_data.data1 = d1;
    q_wr.wr_data.data2 = d2;
    q_wr.wr_data.check = is_d ? sum : xr;
  end

endmodule

// ===== hw/rtl/ptzenc_queue.sv =====
// Short descriptor queue between the front end and the byte serializer.
// Depends on ptzenc_pkg for depth, pointer widths and the entry type.
`timescale 1ns / 1ps

module ptzenc_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  ptzenc_pkg::q_wr_t      q_wr,
  input  logic                   rd_en,
  output logic                   full,
  output ptzenc_pkg::q_rd_t      q_rd
);

  ptzenc_pkg::frame_desc_t mem [ptzenc_pkg::QDEPTH];

  logic [ptzenc_pkg::QPTR_W-1:0] wr_ptr;
  logic [ptzenc_pkg::QPTR_W-1:0] rd_ptr;
  logic [ptzenc_pkg::QCNT_W-1:0] count;

  localparam logic [ptzenc_pkg::QPTR_W-1:0] PTR_LAST =
    ptzenc_pkg::QPTR_W'(ptzenc_pkg::QDEPTH - 1);
  localparam logic [ptzenc_pkg::QCNT_W-1:0] CNT_FULL =
    ptzenc_pkg::QCNT_W'(ptzenc_pkg::QDEPTH);

  logic do_wr;
  logic do_rd;

  assign full         = (count == CNT_FULL);
  assign q_rd.empty   = (count == '0);
  assign q_rd.rd_data = mem[rd_ptr];
  assign do_wr        = q_wr.wr_en && !full;
  assign do_rd        = rd_en && !q_rd.empty;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= q_wr.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/ptzenc_back.sv =====
// Back end: walks one frame descriptor byte by byte into the output register.
// Depends on ptzenc_pkg for the descriptor type and frame constants.
`timescale 1ns / 1ps

module ptzenc_back (
  input  logic                   clk,
  input  logic                   rst,
  input  ptzenc_pkg::q_rd_t      q_rd,
  output logic                   rd_en,
  input  logic                   pop,
  output logic                   empty,
  output logic [7:0]             frame_byte,
  output logic                   last_byte
);

  ptzenc_pkg::frame_desc_t cur;
  logic                    active;
  logic [2:0]              idx;
  logic                    out_valid;

  logic       out_free;
  logic       at_last;
  logic       emit;
  logic [7:0] sel_byte;

  always_comb begin
    out_free = !out_valid || pop;
    at_last  = (idx == (cur.is_p ? ptzenc_pkg::POS_SEVEN : ptzenc_pkg::POS_SIX));
    emit     = active && out_free;
    // fetch the next frame while idle or as the current one sends its last byte
    rd_en    = !q_rd.empty && (!active || (emit && at_last));
    case (idx)
      ptzenc_pkg::POS_HEAD:  sel_byte = cur.is_p ? ptzenc_pkg::P_STX : ptzenc_pkg::D_SYNC;
      ptzenc_pkg::POS_ADDR:  sel_byte = cur.addr;
      ptzenc_pkg::POS_CMD1:  sel_byte = cur.cmd1;
      ptzenc_pkg::POS_CMD2:  sel_byte = cur.cmd2;
      ptzenc_pkg::POS_DATA1: sel_byte = cur.data1;
      ptzenc_pkg::POS_DATA2: sel_byte = cur.data2;
      ptzenc_pkg::POS_SIX:   sel_byte = cur.is_p ? ptzenc_pkg::P_ETX : cur.check;
      default:               sel_byte = cur.check;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      cur <= q_rd.rd_data;
    end
    if (emit) begin
      frame_byte <= sel_byte;
      last_byte  <= at_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (rd_en) begin
        active <= 1'b1;
        idx    <= '0;
      end else if (emit) begin
        if (at_last) begin
          active <= 1'b0;
        end
        idx <= idx + 1'b1;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign empty = !out_valid;

endmodule

// ===== hw/rtl/ptz_command_frame_encoder_top.sv =====
// PTZ command frame encoder top: Pelco-D (7 byte) or Pelco-P (8 byte) frames.
// A taken command goes into the queue, then the current-frame register, then the output register.
// Throughput: one byte per cycle while pop keeps the output free; a frame is 7 (D) or 8 (P) bytes.
// A two-entry descriptor queue lets commands be taken while a frame is still going out.
// Reset (rst, synchronous): queue and output empty, protocol_select = 0, camera_address = 1.
`timescale 1ns / 1ps

module ptz_command_frame_encoder_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       push,
  output logic       full,
  input  logic [3:0] cmd,
  input  logic       enable,
  input  logic [7:0] pan_speed,
  input  logic [7:0] tilt_speed,
  input  logic [7:0] preset_number,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] frame_byte,
  output logic       last_byte
);

  ptzenc_pkg::q_wr_t q_wr;
  ptzenc_pkg::q_rd_t q_rd;
  logic              rd_en;

  assign cfg_ready = 1'b1;

  ptzenc_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_valid && cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .push          (push),
    .q_full        (full),
    .cmd           (cmd),
    .enable        (enable),
    .pan_speed     (pan_speed),
    .tilt_speed    (tilt_speed),
    .preset_number (preset_number),
    .q_wr          (q_wr)
  );

  ptzenc_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .q_wr  (q_wr),
    .rd_en (rd_en),
    .full  (full),
    .q_rd  (q_rd)
  );

  ptzenc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_rd       (q_rd),
    .rd_en      (rd_en),
    .pop        (pop),
    .empty      (empty),
    .frame_byte (frame_byte),
    .last_byte  (last_byte)
  );

endmodule
